@@ rtl/afc_pkg.sv @@
`default_nettype none

package afc_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_MESHES = 65536;

  localparam int NUM_PAIRS  = 8;
  localparam int NUM_ROWS   = 4;
  localparam int NUM_AXES   = 3;
  localparam int NUM_PLANES = 6;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_W      = 64;
  localparam int ENT_W      = 32;   // one matrix entry, signed Q16.16
  localparam int PL_W       = 33;   // plane component, exact sum of two entries
  localparam int CTR_W      = 17;
  localparam int IDX_W      = 16;
  localparam int SIZE_W     = 31;

  localparam int PROD_W     = 64;   // entry * center, signed
  localparam int DOT_W      = 65;   // three such products
  localparam int APROD_W    = 63;   // |plane| * size, unsigned
  localparam int ASUM_W     = 65;   // three such products
  localparam int TOT_W      = 68;   // full plane test value

  localparam logic [CTR_W-1:0] CTR_MAX = CTR_W'(MAX_MESHES);
  localparam logic [CTR_W-1:0] IDX_CAP = CTR_W'(MAX_MESHES - 1);

  typedef logic [CFG_W-1:0] vp_regs_t [NUM_PAIRS];

  // Identity view-projection matrix.
  localparam vp_regs_t VP_RESET = '{
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0000_0000,
    64'h0000_0000_0001_0000,
    64'h0000_0000_0000_0000,
    64'h0001_0000_0000_0000
  };

  // Matrix entry m[idx], column-major; row r component i is m[4*i + r].
  function automatic logic signed [ENT_W-1:0] vp_entry(vp_regs_t vp, int idx);
    logic [3:0]       e;
    logic [CFG_W-1:0] w;
    e = 4'(idx);
    w = vp[e[3:1]];
    return e[0] ? w[63:32] : w[31:0];
  endfunction

endpackage

`default_nettype wire

@@ rtl/aabb_frustum_cull.sv @@
// Pipeline: an accepted box word passes register stages for inputs, products, partial sums,
// then the result register, after which res_valid goes high.
// Throughput: one box per cycle; res_stall back-pressures the chain stage by stage.
// Reset: clears all stage valids and both counters and loads the identity matrix.
// Plane registers are loaded from the matrix registers, so they follow a matrix write in the next cycle.
`default_nettype none

module aabb_frustum_cull
  import afc_pkg::*;
(
  input  wire                     clk,
  input  wire                     rst,

  // configuration
  input  wire                     cfg_we,
  input  wire [CFG_IDX_W-1:0]     cfg_index,
  input  wire [CFG_W-1:0]         cfg_data,

  // box channel
  input  wire                     box_valid,
  output logic                    box_stall,
  input  wire signed [ENT_W-1:0]  center_x,
  input  wire signed [ENT_W-1:0]  center_y,
  input  wire signed [ENT_W-1:0]  center_z,
  input  wire [SIZE_W-1:0]        size_x,
  input  wire [SIZE_W-1:0]        size_y,
  input  wire [SIZE_W-1:0]        size_z,
  input  wire                     last_mesh,

  // result channel
  output logic                    res_valid,
  input  wire                     res_stall,
  output logic [IDX_W-1:0]        mesh_index,
  output logic                    visible,
  output logic [CTR_W-1:0]        culled_count,
  output logic [CTR_W-1:0]        total_count,
  output logic                    scene_done
);

  // ---------------------------------------------------------------------------
  // Matrix registers and derived planes.
  // Plane p uses row r = p/2: even p is row3 + row r, odd p is row3 - row r.
  // Only |a|,|b|,|c| and d are kept; the signed a,b,c part of the test is
  // linear, so it is done as row dot products and combined at the end.
  // ---------------------------------------------------------------------------
  vp_regs_t vp;

  always_ff @(posedge clk) begin
    if (rst) begin
      vp <= VP_RESET;
    end else if (cfg_we) begin
      vp[cfg_index] <= cfg_data;
    end
  end

  logic        [PL_W-1:0]        pl_abs      [NUM_PLANES][NUM_AXES];
  logic signed [PL_W-1:0]        pl_d        [NUM_PLANES];
  logic        [PL_W-1:0]        pl_abs_next [NUM_PLANES][NUM_AXES];
  logic signed [PL_W-1:0]        pl_d_next   [NUM_PLANES];

  always_comb begin
    logic signed [PL_W-1:0] w;
    logic signed [PL_W-1:0] v;
    logic signed [PL_W-1:0] comp;
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int i = 0; i < NUM_ROWS; i++) begin
        w    = PL_W'(vp_entry(vp, 4*i + 3));
        v    = PL_W'(vp_entry(vp, 4*i + p/2));
        comp = (p % 2 == 1) ? (w - v) : (w + v);
        if (i == NUM_ROWS - 1) begin
          pl_d_next[p] = comp;
        end else begin
          pl_abs_next[p][i] = comp[PL_W-1] ? PL_W'(-comp) : PL_W'(comp);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pl_abs <= pl_abs_next;
    pl_d   <= pl_d_next;
  end

  // ---------------------------------------------------------------------------
  // Handshake: each stage loads when it is empty or its word moves on.
  // ---------------------------------------------------------------------------
  logic v0, v1, v2;
  logic rdy0, rdy1, rdy2, rdy_out;
  logic accept, ld1, ld2, ld3;

  assign rdy_out   = !res_valid || !res_stall;
  assign rdy2      = !v2 || rdy_out;
  assign rdy1      = !v1 || rdy2;
  assign rdy0      = !v0 || rdy1;
  assign accept    = box_valid && rdy0;
  assign ld1       = v0 && rdy1;
  assign ld2       = v1 && rdy2;
  assign ld3       = v2 && rdy_out;
  assign box_stall = !rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0        <= 1'b0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      v0        <= accept || (v0 && !rdy1);
      v1        <= ld1 || (v1 && !rdy2);
      v2        <= ld2 || (v2 && !rdy_out);
      res_valid <= ld3 || (res_valid && res_stall);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 0: input register
  // ---------------------------------------------------------------------------
  logic signed [ENT_W-1:0]  s0_c [NUM_AXES];
  logic        [SIZE_W-1:0] s0_s [NUM_AXES];
  logic                     s0_last;

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_c[0] <= center_x;
      s0_c[1] <= center_y;
      s0_c[2] <= center_z;
      s0_s[0] <= size_x;
      s0_s[1] <= size_y;
      s0_s[2] <= size_z;
      s0_last <= last_mesh;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: products. Row r dot center terms, and |plane| * full size terms
  // (full size against twice the center distance keeps the test exact).
  // ---------------------------------------------------------------------------
  logic signed [PROD_W-1:0]  rc_next [NUM_ROWS][NUM_AXES];
  logic        [APROD_W-1:0] as_next [NUM_PLANES][NUM_AXES];
  logic signed [PROD_W-1:0]  s1_rc   [NUM_ROWS][NUM_AXES];
  logic        [APROD_W-1:0] s1_as   [NUM_PLANES][NUM_AXES];
  logic                      s1_last;

  always_comb begin
    logic signed [ENT_W-1:0] m;
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        m           = vp_entry(vp, 4*i + r);
        rc_next[r][i] = PROD_W'(m) * PROD_W'(s0_c[i]);
      end
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int i = 0; i < NUM_AXES; i++) begin
        as_next[p][i] = APROD_W'(pl_abs[p][i]) * APROD_W'(s0_s[i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_rc   <= rc_next;
      s1_as   <= as_next;
      s1_last <= s0_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: three-term sums
  // ---------------------------------------------------------------------------
  logic signed [DOT_W-1:0]  dot_next  [NUM_ROWS];
  logic        [ASUM_W-1:0] asum_next [NUM_PLANES];
  logic signed [DOT_W-1:0]  s2_dot    [NUM_ROWS];
  logic        [ASUM_W-1:0] s2_asum   [NUM_PLANES];
  logic                     s2_last;

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      dot_next[r] = DOT_W'(s1_rc[r][0]) + DOT_W'(s1_rc[r][1]) + DOT_W'(s1_rc[r][2]);
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      asum_next[p] = ASUM_W'(s1_as[p][0]) + ASUM_W'(s1_as[p][1]) + ASUM_W'(s1_as[p][2]);
    end
  end

  always_ff @(posedge clk) begin
    if (ld2) begin
      s2_dot  <= dot_next;
      s2_asum <= asum_next;
      s2_last <= s1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: plane test, counters, result register.
  // Test value per plane, scaled by 2^(2*FRAC_BITS+1):
  //   2*(row3.c +/- rowr.c) + d*2^(FRAC_BITS+1) + sum |n_i|*size_i
  // ---------------------------------------------------------------------------
  logic                     vis_next;

  always_comb begin
    logic signed [TOT_W-1:0] lin;
    logic signed [TOT_W-1:0] tot;
    vis_next = 1'b1;
    for (int p = 0; p < NUM_PLANES; p++) begin
      lin = (p % 2 == 1) ? (TOT_W'(s2_dot[3]) - TOT_W'(s2_dot[p/2]))
                         : (TOT_W'(s2_dot[3]) + TOT_W'(s2_dot[p/2]));
      tot = (lin <<< 1) + (TOT_W'(pl_d[p]) <<< (FRAC_BITS + 1))
          + $signed({{(TOT_W-ASUM_W){1'b0}}, s2_asum[p]});
      if (tot[TOT_W-1]) begin
        vis_next = 1'b0;
      end
    end
  end

  logic [CTR_W-1:0] mesh_counter, culled_counter;
  logic [CTR_W-1:0] mesh_inc, culled_inc;
  logic [IDX_W-1:0] idx_next;

  assign idx_next   = (mesh_counter < IDX_CAP) ? mesh_counter[IDX_W-1:0]
                                               : IDX_CAP[IDX_W-1:0];
  assign mesh_inc   = (mesh_counter < CTR_MAX) ? mesh_counter + 1'b1 : mesh_counter;
  assign culled_inc = (!vis_next && culled_counter < CTR_MAX) ? culled_counter + 1'b1
                                                              : culled_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      mesh_counter   <= '0;
      culled_counter <= '0;
    end else if (ld3) begin
      mesh_counter   <= s2_last ? '0 : mesh_inc;
      culled_counter <= s2_last ? '0 : culled_inc;
    end
  end

  always_ff @(posedge clk) begin
    if (ld3) begin
      mesh_index   <= idx_next;
      visible      <= vis_next;
      culled_count <= culled_inc;
      total_count  <= mesh_inc;
      scene_done   <= s2_last;
    end
  end

`ifndef SYNTHESIS
  a_mesh_sat: assert property (@(posedge clk) disable iff (rst)
    mesh_counter <= CTR_MAX)
    else $error("mesh counter past saturation");

  a_culled_le_mesh: assert property (@(posedge clk) disable iff (rst)
    culled_counter <= mesh_counter)
    else $error("culled counter above mesh counter");

  a_scene_clear: assert property (@(posedge clk) disable iff (rst)
    ld3 && s2_last |=> mesh_counter == '0 && culled_counter == '0)
    else $error("counters not cleared after scene end");

  a_res_counts: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> culled_count <= total_count && total_count != '0)
    else $error("result counts inconsistent");

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    v2 && !rdy_out |=> v2 && $stable(s2_last))
    else $error("stage 2 word lost under stall");
`endif

endmodule

`default_nettype wire
